FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds at every clock edge outside reset.
`define MCFD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define MCFD_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/mcfd_pkg.sv
package mcfd_pkg;

   localparam int NUM_CHAN_DEF = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [7:0]  MAGIC_BYTE    = 8'h82;
   localparam logic [7:0]  MIN_LEN       = 8'd4;
   localparam logic [15:0] FAILSAFE_RST  = 16'd100;
   localparam logic [7:0]  TIMEOUT_RST   = 8'd2;
   localparam logic [15:0] PWM_OFFSET    = 16'd1000;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAILSAFE_TICKS   = 1'b0,
      CSR_RX_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL   = 2'd0,
      KIND_STOP      = 2'd1,
      KIND_FRAME_ERR = 2'd2,
      KIND_CRC_ERR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EM_IDLE  = 2'd0,
      EM_EVENT = 2'd1,
      EM_DRAIN = 2'd2
   } em_state_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  channel;
      logic [15:0] pwm;
      logic        telem_req;
      logic        last;
      logic [15:0] frame_error_count;
      logic [15:0] crc_error_count;
   } rsp_type;

   // What one accepted item leaves for the result side.
   typedef struct packed {
      logic     valid;
      logic     err_valid;
      kind_type err_kind;
      logic     stop;
      logic     drain;
   } event_type;

   typedef struct packed {
      logic [15:0] frame_errors;
      logic [15:0] crc_fails;
   } counts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   localparam logic [15:0] CRC_MAGIC = crc_byte(16'h0000, MAGIC_BYTE);

endpackage

FILE: rtl/motor_command_frame_decoder.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data  (mode, rx_byte)
// rsp_      out        rsp_valid / rsp_ready  rsp_data  (kind ... crc_error_count)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// An item that gives no result leaves req_ready high.
// An error or stop item gives one or two results; req_ready stays low until the last
// is loaded. A good frame end reads each channel word from the word store into the
// read register and then the output register, one word a cycle unless rsp_ stalls.
// Reset is synchronous and active high; the store needs no clearing pass.
// A stalled rsp_ channel holds the sequencer; the last result may still wait in
// the output register while the next item is accepted.
module motor_command_frame_decoder
   import mcfd_pkg::*;
#(
   parameter int NUM_CHAN = NUM_CHAN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(NUM_CHAN + 1);
   localparam int AW    = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;

   logic             accept;
   logic             idle;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [15:0]      wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [15:0]      rd_data;
   event_type        evt;
   logic [CNT_W-1:0] nch;
   counts_type       counts;

   assign req_ready = idle;
   assign accept    = req_valid && idle;

   mcfd_parser #(
      .NUM_CHAN(NUM_CHAN)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .evt       (evt),
      .nch       (nch),
      .counts    (counts)
   );

   mcfd_store #(
      .DEPTH(NUM_CHAN),
      .AW   (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcfd_emitter #(
      .NUM_CHAN(NUM_CHAN)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .nch       (nch),
      .counts    (counts),
      .idle      (idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/mcfd_store.sv
module mcfd_store
   import mcfd_pkg::*;
#(
   parameter int DEPTH = NUM_CHAN_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mcfd_parser.sv
`include "assert_macros.svh"

module mcfd_parser
   import mcfd_pkg::*;
#(
   parameter  int NUM_CHAN = NUM_CHAN_DEF,
   localparam int CNT_W    = $clog2(NUM_CHAN + 1),
   localparam int AW       = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  req_type                req,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [15:0]            wr_data,
   output event_type              evt,
   output logic [CNT_W-1:0]       nch,
   output counts_type             counts
);

   localparam logic [7:0] MAX_LEN = 8'(4 + 2 * NUM_CHAN);

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  lowb_ff, lowb_in;
   logic [15:0] tsg_ff, tsg_in;
   logic [7:0]  tif_ff, tif_in;
   logic        stopped_ff, stopped_in;
   logic [15:0] ferr_ff, ferr_in;
   logic [15:0] cerr_ff, cerr_in;
   logic [15:0] failsafe_ff, failsafe_in;
   logic [7:0]  timeout_ff, timeout_in;

   logic [7:0]  b;
   logic [7:0]  pos;
   logic [6:0]  word;
   logic [7:0]  lim;
   logic [7:0]  tif_sat;
   logic [15:0] tsg_sat;
   logic [7:0]  nch_full;

   assign b        = req.rx_byte;
   assign pos      = idx_ff - 8'd2;
   assign word     = pos[7:1];
   assign lim      = (timeout_ff == 8'd0) ? 8'd1 : timeout_ff;
   assign tif_sat  = sat_inc8(tif_ff);
   assign tsg_sat  = sat_inc16(tsg_ff);
   assign nch_full = (len_ff - MIN_LEN) >> 1;

   always_comb begin
      failsafe_in = failsafe_ff;
      timeout_in  = timeout_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAILSAFE_TICKS:   failsafe_in = csr_wdata;
            CSR_RX_TIMEOUT_TICKS: timeout_in  = csr_wdata[7:0];
            default:              failsafe_in = failsafe_ff;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      lowb_in    = lowb_ff;
      tsg_in     = tsg_ff;
      tif_in     = tif_ff;
      stopped_in = stopped_ff;
      ferr_in    = ferr_ff;
      cerr_in    = cerr_ff;
      evt        = '0;
      evt.valid  = accept;
      wr_en      = 1'b0;

      if (accept && req.mode) begin
         if (phase_ff != PH_HUNT) begin
            tif_in = tif_sat;
            if (tif_sat >= lim) begin
               ferr_in       = sat_inc16(ferr_ff);
               evt.err_valid = 1'b1;
               evt.err_kind  = KIND_FRAME_ERR;
               phase_in      = PH_HUNT;
               idx_in        = 8'd0;
               crc_in        = 16'd0;
               tif_in        = 8'd0;
            end
         end
         tsg_in = tsg_sat;
         if (!stopped_ff && tsg_sat >= failsafe_ff) begin
            stopped_in = 1'b1;
            evt.stop   = 1'b1;
         end
      end else if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == MAGIC_BYTE) begin
                  crc_in   = CRC_MAGIC;
                  phase_in = PH_LEN;
                  idx_in   = 8'd1;
                  tif_in   = 8'd0;
               end
            end
            PH_LEN: begin
               if (b < MIN_LEN || b > MAX_LEN) begin
                  ferr_in       = sat_inc16(ferr_ff);
                  evt.err_valid = 1'b1;
                  evt.err_kind  = KIND_FRAME_ERR;
                  phase_in      = PH_HUNT;
                  idx_in        = 8'd0;
                  crc_in        = 16'd0;
                  tif_in        = 8'd0;
               end else begin
                  len_in   = b;
                  crc_in   = crc_byte(crc_ff, b);
                  idx_in   = 8'd2;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               lowb_in = b;
               // A word is complete on every odd payload byte.
               wr_en   = pos[0] && (word < 7'(NUM_CHAN));
               if (({1'b0, idx_ff} + 9'd2) < {1'b0, len_ff}) begin
                  crc_in = crc_byte(crc_ff, b);
               end
               idx_in = idx_ff + 8'd1;
               if (({1'b0, idx_ff} + 9'd1) >= {1'b0, len_ff}) begin
                  // The trailer is the previous byte and this one, little-endian.
                  if ({b, lowb_ff} != crc_ff) begin
                     cerr_in       = sat_inc16(cerr_ff);
                     evt.err_valid = 1'b1;
                     evt.err_kind  = KIND_CRC_ERR;
                  end else begin
                     tsg_in     = 16'd0;
                     stopped_in = 1'b0;
                     evt.drain  = (nch_full != 8'd0);
                  end
                  phase_in = PH_HUNT;
                  idx_in   = 8'd0;
                  crc_in   = 16'd0;
                  tif_in   = 8'd0;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               idx_in   = 8'd0;
               crc_in   = 16'd0;
               tif_in   = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         len_ff      <= 8'd0;
         idx_ff      <= 8'd0;
         crc_ff      <= 16'd0;
         tsg_ff      <= 16'd0;
         tif_ff      <= 8'd0;
         stopped_ff  <= 1'b0;
         ferr_ff     <= 16'd0;
         cerr_ff     <= 16'd0;
         failsafe_ff <= FAILSAFE_RST;
         timeout_ff  <= TIMEOUT_RST;
      end else begin
         phase_ff    <= phase_in;
         len_ff      <= len_in;
         idx_ff      <= idx_in;
         crc_ff      <= crc_in;
         tsg_ff      <= tsg_in;
         tif_ff      <= tif_in;
         stopped_ff  <= stopped_in;
         ferr_ff     <= ferr_in;
         cerr_ff     <= cerr_in;
         failsafe_ff <= failsafe_in;
         timeout_ff  <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      lowb_ff <= lowb_in;
   end

   assign wr_addr = word[AW-1:0];
   assign wr_data = {b, lowb_ff};
   assign nch     = nch_full[CNT_W-1:0];
   assign counts  = '{frame_errors: ferr_ff, crc_fails: cerr_ff};

   `MCFD_ASSERT_IMPL(a_body_index_in_frame, phase_ff == PH_BODY,
      idx_ff < len_ff && len_ff >= MIN_LEN && len_ff <= MAX_LEN,
      "byte index ran past the frame length")
   `MCFD_ASSERT_IMPL(a_stop_only_on_tick, $rose(stopped_ff),
      $past(accept) && $past(req.mode), "stop flag set without a tick")
   `MCFD_ASSERT_IMPL(a_hunt_is_clear, phase_ff == PH_HUNT,
      idx_ff == 8'd0 && tif_ff == 8'd0 && crc_ff == 16'd0,
      "frame state left over while hunting")

endmodule

FILE: rtl/mcfd_emitter.sv
`include "assert_macros.svh"

module mcfd_emitter
   import mcfd_pkg::*;
#(
   parameter  int NUM_CHAN = NUM_CHAN_DEF,
   localparam int CNT_W    = $clog2(NUM_CHAN + 1),
   localparam int AW       = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  event_type        evt,
   input  logic [CNT_W-1:0] nch,
   input  counts_type       counts,
   output logic             idle,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   input  logic [15:0]      rd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   em_state_type     state_ff, state_in;
   logic             pend_err_ff, pend_err_in;
   kind_type         err_kind_ff, err_kind_in;
   logic             pend_stop_ff, pend_stop_in;
   logic [CNT_W-1:0] nch_ff, nch_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] data_idx_ff, data_idx_in;
   logic             data_valid_ff, data_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        load_err;
   logic        load_stop;
   logic        load_word;
   logic        issue;
   logic        word_last;
   logic [14:0] low;

   assign word_last = (data_idx_ff == (nch_ff - CNT_W'(1)));
   assign low       = rd_data[14:0];

   // Output decode of the result sequencer.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      load_err  = (state_ff == EM_EVENT) && pend_err_ff && out_free;
      load_stop = (state_ff == EM_EVENT) && !pend_err_ff && pend_stop_ff && out_free;
      load_word = (state_ff == EM_DRAIN) && data_valid_ff && out_free;
      // A word is fetched only when the read register is empty or emptying.
      issue     = (state_ff == EM_DRAIN) && (rd_cnt_ff < nch_ff) &&
                  (!data_valid_ff || load_word);
      idle      = (state_ff == EM_IDLE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (evt.valid && (evt.err_valid || evt.stop)) begin
               state_in = EM_EVENT;
            end else if (evt.valid && evt.drain) begin
               state_in = EM_DRAIN;
            end
         end
         EM_EVENT: begin
            if ((load_err && !pend_stop_ff) || load_stop) begin
               state_in = EM_IDLE;
            end
         end
         EM_DRAIN: begin
            if (load_word && word_last) begin
               state_in = EM_IDLE;
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_comb begin
      pend_err_in   = pend_err_ff;
      err_kind_in   = err_kind_ff;
      pend_stop_in  = pend_stop_ff;
      nch_in        = nch_ff;
      rd_cnt_in     = rd_cnt_ff;
      data_idx_in   = data_idx_ff;
      data_valid_in = data_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (state_ff == EM_IDLE && evt.valid) begin
         pend_err_in  = evt.err_valid;
         err_kind_in  = evt.err_kind;
         pend_stop_in = evt.stop;
         nch_in       = nch;
         rd_cnt_in    = '0;
      end

      if (load_err || load_stop || load_word) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in                   = '0;
         rsp_data_in.frame_error_count = counts.frame_errors;
         rsp_data_in.crc_error_count   = counts.crc_fails;
      end

      if (load_err) begin
         rsp_data_in.kind = err_kind_ff;
         rsp_data_in.last = !pend_stop_ff;
         pend_err_in      = 1'b0;
      end else if (load_stop) begin
         rsp_data_in.kind = KIND_STOP;
         rsp_data_in.last = 1'b1;
         pend_stop_in     = 1'b0;
      end else if (load_word) begin
         rsp_data_in.kind      = KIND_CHANNEL;
         rsp_data_in.channel   = 3'(data_idx_ff);
         rsp_data_in.pwm       = (low == 15'd0) ? 16'd0 : PWM_OFFSET + {1'b0, low};
         rsp_data_in.telem_req = rd_data[15];
         rsp_data_in.last      = word_last;
      end

      if (issue) begin
         rd_cnt_in     = rd_cnt_ff + CNT_W'(1);
         data_idx_in   = rd_cnt_ff;
         data_valid_in = 1'b1;
      end else if (load_word) begin
         data_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= EM_IDLE;
         pend_err_ff   <= 1'b0;
         pend_stop_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_err_ff   <= pend_err_in;
         pend_stop_ff  <= pend_stop_in;
         rd_cnt_ff     <= rd_cnt_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_kind_ff <= err_kind_in;
      nch_ff      <= nch_in;
      data_idx_ff <= data_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rd_en     = issue;
   assign rd_addr   = rd_cnt_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MCFD_ASSERT(a_read_lands, issue |=> data_valid_ff,
      "a word fetch did not land in the read register")
   `MCFD_ASSERT_IMPL(a_read_in_range, state_ff == EM_DRAIN,
      rd_cnt_ff <= nch_ff && nch_ff != '0, "channel fetch ran past the word count")
   `MCFD_ASSERT_IMPL(a_no_event_when_busy, state_ff != EM_IDLE, !evt.valid,
      "an item arrived while results were still pending")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mcfd_pkg::*;

   localparam int FRAME_MAX   = int'(MIN_LEN) + 2 * NUM_CHAN_DEF;
   localparam int STORE_DEPTH = 2 * NUM_CHAN_DEF + 2;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 12;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int counted_items = 0;

   // Decoder state as predicted by the testbench.
   phase_type   parse_state;
   logic [7:0]  frame_len;
   logic [7:0]  byte_pos;
   logic [7:0]  rx_ticks;
   logic [7:0]  timeout_reg;
   logic [15:0] crc_run;
   logic [15:0] idle_ticks;
   logic [15:0] failsafe_reg;
   logic [15:0] frame_err_cnt;
   logic [15:0] crc_err_cnt;
   logic [7:0]  body_bytes [STORE_DEPTH];
   logic        stop_sent;

   rsp_type     decoded_q[$];
   logic [7:0]  frame_buf[$];

   motor_command_frame_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[motor_command_frame_decoder] ERROR");
         $finish;
      end
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("result of kind %0d with none expected",
                                      rsp_data.kind));
         end else begin
            want = decoded_q.pop_front();
            check_field("kind", 16'(rsp_data.kind), 16'(want.kind));
            check_field("channel", 16'(rsp_data.channel), 16'(want.channel));
            check_field("pwm", rsp_data.pwm, want.pwm);
            check_field("telem_req", 16'(rsp_data.telem_req),
                        16'(want.telem_req));
            check_field("last", 16'(rsp_data.last), 16'(want.last));
            check_field("frame_error_count", rsp_data.frame_error_count,
                        want.frame_error_count);
            check_field("crc_error_count", rsp_data.crc_error_count,
                        want.crc_error_count);
         end
      end
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc;
      for (int k = 7; k >= 0; k--) begin
         if (c[15] ^ b[k]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic rsp_type make_rsp(input kind_type k, input int chan,
                                        input logic [15:0] pw, input logic telem);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.channel = 3'(chan);
      r.pwm = pw;
      r.telem_req = telem;
      return r;
   endfunction

   function automatic void restart_hunt();
      parse_state = PH_HUNT;
      byte_pos = 8'd0;
      crc_run = 16'd0;
      rx_ticks = 8'd0;
   endfunction

   function automatic void reset_model();
      failsafe_reg = FAILSAFE_RST;
      timeout_reg = TIMEOUT_RST;
      restart_hunt();
      frame_len = 8'd0;
      idle_ticks = 16'd0;
      stop_sent = 1'b0;
      frame_err_cnt = 16'd0;
      crc_err_cnt = 16'd0;
      foreach (body_bytes[k]) body_bytes[k] = 8'd0;
   endfunction

   // Works out the results of one accepted item and queues them.
   function automatic void decode_item(input req_type item);
      rsp_type     step_out[$];
      int          pos;
      int          nch;
      int          i;
      logic [15:0] word;
      logic [15:0] trailer;
      logic [7:0]  lim;
      if (item.mode == 1'b0) begin
         case (parse_state)
            PH_HUNT: begin
               if (item.rx_byte == MAGIC_BYTE) begin
                  crc_run = crc16_next(16'h0000, item.rx_byte);
                  parse_state = PH_LEN;
                  byte_pos = 8'd1;
                  rx_ticks = 8'd0;
               end
            end
            PH_LEN: begin
               if (item.rx_byte < MIN_LEN || int'(item.rx_byte) > FRAME_MAX) begin
                  if (frame_err_cnt != 16'hFFFF) frame_err_cnt++;
                  step_out.push_back(make_rsp(KIND_FRAME_ERR, 0, 16'd0, 1'b0));
                  restart_hunt();
               end else begin
                  frame_len = item.rx_byte;
                  crc_run = crc16_next(crc_run, item.rx_byte);
                  byte_pos = 8'd2;
                  parse_state = PH_BODY;
               end
            end
            default: begin
               pos = int'(byte_pos) - 2;
               if (pos < STORE_DEPTH) body_bytes[pos] = item.rx_byte;
               // The two trailer bytes stay out of the checksum.
               if (int'(byte_pos) + 2 < int'(frame_len)) begin
                  crc_run = crc16_next(crc_run, item.rx_byte);
               end
               byte_pos++;
               if (byte_pos >= frame_len) begin
                  trailer = {body_bytes[int'(frame_len) - 3], body_bytes[int'(frame_len) - 4]};
                  if (trailer != crc_run) begin
                     if (crc_err_cnt != 16'hFFFF) crc_err_cnt++;
                     step_out.push_back(make_rsp(KIND_CRC_ERR, 0, 16'd0, 1'b0));
                  end else begin
                     nch = (int'(frame_len) - 4) / 2;
                     for (i = 0; i < nch; i++) begin
                        word = {body_bytes[2 * i + 1], body_bytes[2 * i]};
                        step_out.push_back(make_rsp(KIND_CHANNEL, i,
                           (word[14:0] != 15'd0) ? PWM_OFFSET + {1'b0, word[14:0]} : 16'd0,
                           word[15]));
                     end
                     idle_ticks = 16'd0;
                     stop_sent = 1'b0;
                  end
                  restart_hunt();
               end
            end
         endcase
      end else begin
         if (parse_state != PH_HUNT) begin
            lim = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
            if (rx_ticks != 8'hFF) rx_ticks++;
            if (rx_ticks >= lim) begin
               if (frame_err_cnt != 16'hFFFF) frame_err_cnt++;
               step_out.push_back(make_rsp(KIND_FRAME_ERR, 0, 16'd0, 1'b0));
               restart_hunt();
            end
         end
         if (idle_ticks != 16'hFFFF) idle_ticks++;
         if (!stop_sent && idle_ticks >= failsafe_reg) begin
            stop_sent = 1'b1;
            step_out.push_back(make_rsp(KIND_STOP, 0, 16'd0, 1'b0));
         end
      end
      // Every result of a step carries the counts as they stand after the step.
      foreach (step_out[k]) begin
         step_out[k].last = (k == step_out.size() - 1);
         step_out[k].frame_error_count = frame_err_cnt;
         step_out[k].crc_error_count = crc_err_cnt;
         decoded_q.push_back(step_out[k]);
      end
   endfunction

   // Called just after a rising edge; returns at the edge where the transfer happened.
   task automatic send_cmd(input logic mode, input logic [7:0] value);
      int      gap;
      req_type item;
      gap = 0;
      item.mode = mode;
      item.rx_byte = value;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      decode_item(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FAILSAFE_TICKS) begin
         failsafe_reg = value;
      end else begin
         timeout_reg = value[7:0];
      end
   endtask

   function automatic void start_frame(input int len);
      frame_buf.delete();
      frame_buf.push_back(MAGIC_BYTE);
      frame_buf.push_back(8'(len));
   endfunction

   // Appends the little-endian checksum, optionally damaged.
   function automatic void seal_frame(input logic [15:0] damage);
      logic [15:0] acc;
      acc = 16'd0;
      foreach (frame_buf[k]) acc = crc16_next(acc, frame_buf[k]);
      acc ^= damage;
      frame_buf.push_back(acc[7:0]);
      frame_buf.push_back(acc[15:8]);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void build_random_frame(input logic [15:0] damage);
      int len;
      len = ($urandom_range(0, 3) == 0) ? FRAME_MAX : $urandom_range(int'(MIN_LEN), FRAME_MAX);
      start_frame(len);
      repeat (len - 4) frame_buf.push_back(pick_byte());
      seal_frame(damage);
   endfunction

   task automatic send_frame(input int upto, input int tick_pct);
      for (int k = 0; k < upto; k++) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            send_cmd(1'b1, 8'($urandom));
            counted_items++;
         end
         send_cmd(1'b0, frame_buf[k]);
         counted_items++;
      end
   endtask

   task automatic test_garbage_and_bad_length();
      send_cmd(1'b0, 8'h00);
      send_cmd(1'b0, 8'hFF);
      send_cmd(1'b0, MAGIC_BYTE);
      send_cmd(1'b0, MIN_LEN - 8'd1);
      send_cmd(1'b0, MAGIC_BYTE);
      send_cmd(1'b0, 8'(FRAME_MAX + 1));
      wait_idle();
   endtask

   task automatic test_good_frames();
      logic [15:0] words [8] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                 16'hFFFF, 16'h8001, 16'h1234, 16'h7FFE};
      start_frame(int'(MIN_LEN));
      seal_frame(16'd0);
      send_frame(frame_buf.size(), 0);
      start_frame(FRAME_MAX);
      foreach (words[k]) begin
         frame_buf.push_back(words[k][7:0]);
         frame_buf.push_back(words[k][15:8]);
      end
      seal_frame(16'd0);
      send_frame(frame_buf.size(), 0);
      // A spare odd byte that still counts in the checksum, with a bad trailer.
      start_frame(5);
      frame_buf.push_back(8'h5A);
      seal_frame(16'h0001);
      send_frame(frame_buf.size(), 0);
      wait_idle();
   endtask

   task automatic test_tick_cases();
      write_reg(CSR_FAILSAFE_TICKS, 16'd1);
      write_reg(CSR_RX_TIMEOUT_TICKS, 16'd1);
      // One tick both aborts the open frame and trips the failsafe.
      send_cmd(1'b0, MAGIC_BYTE);
      send_cmd(1'b1, 8'hA5);
      send_cmd(1'b1, 8'h5A);
      send_cmd(1'b0, MAGIC_BYTE);
      send_cmd(1'b0, 8'd6);
      send_cmd(1'b1, 8'h00);
      wait_idle();
      write_reg(CSR_FAILSAFE_TICKS, 16'd2);
      write_reg(CSR_RX_TIMEOUT_TICKS, 16'd3);
      start_frame(int'(MIN_LEN));
      seal_frame(16'd0);
      send_frame(frame_buf.size(), 0);
      send_cmd(1'b0, MAGIC_BYTE);
      send_cmd(1'b1, 8'h11);
      send_cmd(1'b1, 8'h22);
      send_cmd(1'b1, 8'h33);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [15:0] failsafe, input logic [7:0] timeout,
                                      input int n_items, input int tick_pct);
      int start;
      int pick;
      start = counted_items;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      write_reg(CSR_FAILSAFE_TICKS, failsafe);
      write_reg(CSR_RX_TIMEOUT_TICKS, {8'd0, timeout});
      while (counted_items - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            build_random_frame(16'd0);
            send_frame(frame_buf.size(), tick_pct);
         end else if (pick < 76) begin
            build_random_frame(16'($urandom_range(1, 65535)));
            send_frame(frame_buf.size(), tick_pct);
         end else if (pick < 82) begin
            send_cmd(1'b0, MAGIC_BYTE);
            send_cmd(1'b0, $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(FRAME_MAX + 1, 255)));
            counted_items += 2;
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 3)) begin
               send_cmd(1'b0, 8'($urandom));
               counted_items++;
            end
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 4)) begin
               send_cmd(1'b1, 8'($urandom));
               counted_items++;
            end
         end else begin
            // A cut-off frame: whatever follows lands inside it.
            build_random_frame(16'd0);
            send_frame($urandom_range(1, frame_buf.size() - 1), 0);
         end
      end
      wait_idle();
   endtask

   task automatic test_flow_control();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_reg(CSR_RX_TIMEOUT_TICKS, 16'd255);
      hold_left <= 400;
      repeat (4) begin
         start_frame(FRAME_MAX);
         repeat (FRAME_MAX - 4) frame_buf.push_back(pick_byte());
         seal_frame(16'd0);
         send_frame(frame_buf.size(), 0);
      end
      // The sender now waits for every outstanding result before going on.
      wait_idle();
      build_random_frame(16'd0);
      send_frame(frame_buf.size(), 0);
      wait_idle();
   endtask

   initial begin
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_garbage_and_bad_length();
      test_good_frames();
      test_tick_cases();
      test_random_traffic(31, 56, 16'($urandom_range(2, 40)), 8'($urandom_range(1, 6)),
                          85, 4);
      test_random_traffic(56, 31, 16'hFFFF, 8'd255, 85, 10);
      test_random_traffic(0, 0, 16'd1, 8'($urandom_range(1, 255)), 85, 3);
      test_flow_control();
      if (decoded_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived", decoded_q.size()));
      end
      if (mismatch_count == 0) begin
         $display("[motor_command_frame_decoder] OK");
      end else begin
         $display("[motor_command_frame_decoder] ERROR");
      end
      $finish;
   end

endmodule
